[hdl/stk_pkg.sv]
// ----------------------------------------------------------------------------
// stk_pkg - shared types and constants for the top-k selector
// Cell operation codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package stk_pkg;

    localparam int COUNT_BITS = 32;
    localparam int KEEP_BITS  = 5;
    localparam logic [KEEP_BITS-1:0] KEEP_RESET = 5'd16;

    // what every cell of the row does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_UP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctrl;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

[hdl/stk_in_if.sv]
// ----------------------------------------------------------------------------
// stk_in_if - input channel of the top-k selector
// Valid/ready channel carrying one offer or flush word.
// ----------------------------------------------------------------------------
interface stk_in_if #(
    parameter int KEY_BITS = 48
);
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [KEY_BITS-1:0]            entry_key;
    logic [stk_pkg::COUNT_BITS-1:0] entry_count;

    modport source (output valid, output mode, output entry_key, output entry_count,
                    input ready);
    modport sink   (input valid, input mode, input entry_key, input entry_count,
                    output ready);
endinterface

[hdl/stk_out_if.sv]
// ----------------------------------------------------------------------------
// stk_out_if - result channel of the top-k selector
// Valid/ready channel carrying one emitted entry word.
// ----------------------------------------------------------------------------
interface stk_out_if #(
    parameter int KEY_BITS = 48
);
    logic                           valid;
    logic                           ready;
    logic [KEY_BITS-1:0]            out_key;
    logic [stk_pkg::COUNT_BITS-1:0] out_count;
    logic                           last;
    logic                           empty_res;

    modport source (output valid, output out_key, output out_count, output last,
                    output empty_res, input ready);
    modport sink   (input valid, input out_key, input out_count, input last,
                    input empty_res, output ready);
endinterface

[hdl/stk_cell.sv]
// ----------------------------------------------------------------------------
// stk_cell - one slot of the sorted entry row
// Holds one key/count; takes the new entry, its upper or lower neighbour.
// ----------------------------------------------------------------------------
module stk_cell #(
    parameter int KEY_BITS = 48
) (
    input  logic                           i_clk,
    input  stk_pkg::t_cell_ctrl            i_ctrl,
    input  logic                           i_valid,
    input  logic [KEY_BITS-1:0]            i_new_key,
    input  logic [stk_pkg::COUNT_BITS-1:0] i_new_count,
    input  logic [KEY_BITS-1:0]            i_prev_key,
    input  logic [stk_pkg::COUNT_BITS-1:0] i_prev_count,
    input  logic                           i_prev_ge,
    input  logic [KEY_BITS-1:0]            i_next_key,
    input  logic [stk_pkg::COUNT_BITS-1:0] i_next_count,
    output logic                           o_ge,
    output logic [KEY_BITS-1:0]            o_key,
    output logic [stk_pkg::COUNT_BITS-1:0] o_count
);

    logic [KEY_BITS-1:0]            r_key;
    logic [stk_pkg::COUNT_BITS-1:0] r_count;
    logic [KEY_BITS-1:0]            n_key;
    logic [stk_pkg::COUNT_BITS-1:0] n_count;

    // held entry stays ahead of the new one on equal counts (earlier first)
    assign o_ge    = i_valid && (r_count >= i_new_count);
    assign o_key   = r_key;
    assign o_count = r_count;

    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        case (i_ctrl.op)
            stk_pkg::CELL_INSERT: begin
                if (!o_ge) begin
                    if (i_prev_ge) begin
                        n_key   = i_new_key;
                        n_count = i_new_count;
                    end else begin
                        n_key   = i_prev_key;
                        n_count = i_prev_count;
                    end
                end
            end
            stk_pkg::CELL_SHIFT_UP: begin
                n_key   = i_next_key;
                n_count = i_next_count;
            end
            default: begin
                n_key   = r_key;
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
    end

endmodule

[hdl/streaming_top_k_selector.sv]
// ----------------------------------------------------------------------------
// streaming_top_k_selector - keeps the largest-count keyed entries of a stream
// Row of compare/shift cells kept in descending count order, drained on flush.
// ----------------------------------------------------------------------------
// Usage:
//  i_in carries one word per handshake: mode 0 offers (entry_key, entry_count),
//  mode 1 flushes. o_out carries the flushed entries, largest count first,
//  earlier-accepted first among equal counts, with last on the final word.
//  A flush of an empty store gives one word with empty_res and last set.
//  i_cfg_we/i_cfg_data write keep_count (0 acts as 1, above CAPACITY as
//  CAPACITY); write it only while the block is idle.
//  Rate: offers may follow back to back while no flush is draining; all
//  cells compare against the new count in parallel and shift by one slot.
//  An accepted flush keeps i_in.ready low until its last word is loaded;
//  the row shifts up one slot per word into the output register.
//  In the drain state each word is loaded once that register is free.
//  A stall on o_out holds the output register and the drain; offers are still
//  taken while the last flushed word waits.
//  Reset (synchronous, active low) empties the store, sets keep_count to 16
//  and clears the output valid; both channels are idle while it is held.
// ----------------------------------------------------------------------------
module streaming_top_k_selector #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    stk_in_if.sink                        i_in,
    stk_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [stk_pkg::KEEP_BITS-1:0] i_cfg_data
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > stk_pkg::KEEP_BITS) ? CW : stk_pkg::KEEP_BITS;
    localparam int CB   = stk_pkg::COUNT_BITS;

    stk_pkg::t_state               r_state, n_state;
    logic [CW-1:0]                 r_held, n_held;
    logic [stk_pkg::KEEP_BITS-1:0] r_keep;

    logic                          r_out_valid;
    logic [KEY_BITS-1:0]           r_out_key, n_out_key;
    logic [CB-1:0]                 r_out_count, n_out_count;
    logic                          r_out_last, n_out_last;
    logic                          r_out_empty, n_out_empty;
    logic                          w_load_out;
    logic                          w_out_free;
    logic                          w_in_acc;

    stk_pkg::t_cell_ctrl           w_ctrl;
    logic [CMPW-1:0]               w_keep_eff;
    logic                          w_can_append;
    logic                          w_can_replace;

    logic [CAPACITY-1:0]           w_valid;
    logic [CAPACITY-1:0]           w_ge;
    logic [KEY_BITS-1:0]           w_key   [CAPACITY];
    logic [CB-1:0]                 w_count [CAPACITY];

    // ---- the cell row: slot 0 holds the largest count ----
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_prev_key, w_next_key;
        logic [CB-1:0]       w_prev_count, w_next_count;
        logic                w_prev_ge;

        assign w_valid[g] = (CW'(g) < r_held);

        if (g == 0) begin : g_head
            assign w_prev_key   = i_in.entry_key;
            assign w_prev_count = i_in.entry_count;
            assign w_prev_ge    = 1'b1;
        end else begin : g_body
            assign w_prev_key   = w_key[g-1];
            assign w_prev_count = w_count[g-1];
            assign w_prev_ge    = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_key   = w_key[g];
            assign w_next_count = w_count[g];
        end else begin : g_mid
            assign w_next_key   = w_key[g+1];
            assign w_next_count = w_count[g+1];
        end

        stk_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_valid      (w_valid[g]),
            .i_new_key    (i_in.entry_key),
            .i_new_count  (i_in.entry_count),
            .i_prev_key   (w_prev_key),
            .i_prev_count (w_prev_count),
            .i_prev_ge    (w_prev_ge),
            .i_next_key   (w_next_key),
            .i_next_count (w_next_count),
            .o_ge         (w_ge[g]),
            .o_key        (w_key[g]),
            .o_count      (w_count[g])
        );
    end

    // ---- keep limit: zero acts as one, saturates at capacity ----
    always_comb begin
        w_keep_eff = CMPW'(r_keep);
        if (w_keep_eff == '0) begin
            w_keep_eff = CMPW'(1);
        end else if (w_keep_eff > CMPW'(CAPACITY)) begin
            w_keep_eff = CMPW'(CAPACITY);
        end
    end

    assign w_can_append  = (CMPW'(r_held) < w_keep_eff);
    // row is sorted, so a held slot below the new count means the tail is
    // below it too; the tail is the newest of the smallest counts
    assign w_can_replace = |(w_valid & ~w_ge);

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = i_rst_n && (r_state == stk_pkg::ST_RUN);
    assign w_in_acc   = i_in.valid && i_in.ready;

    // ---- controller ----
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        w_ctrl.op   = stk_pkg::CELL_HOLD;
        w_load_out  = 1'b0;
        n_out_key   = w_key[0];
        n_out_count = w_count[0];
        n_out_last  = (r_held == CW'(1));
        n_out_empty = 1'b0;
        case (r_state)
            stk_pkg::ST_RUN: begin
                if (w_in_acc) begin
                    if (i_in.mode) begin
                        n_state = stk_pkg::ST_DRAIN;
                    end else if (w_can_append) begin
                        w_ctrl.op = stk_pkg::CELL_INSERT;
                        n_held    = r_held + CW'(1);
                    end else if (w_can_replace) begin
                        w_ctrl.op = stk_pkg::CELL_INSERT;
                    end
                end
            end
            stk_pkg::ST_DRAIN: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    if (r_held == '0) begin
                        // flush of an empty store
                        n_out_key   = '0;
                        n_out_count = '0;
                        n_out_last  = 1'b1;
                        n_out_empty = 1'b1;
                        n_state     = stk_pkg::ST_RUN;
                    end else begin
                        w_ctrl.op = stk_pkg::CELL_SHIFT_UP;
                        n_held    = r_held - CW'(1);
                        if (r_held == CW'(1)) begin
                            n_state = stk_pkg::ST_RUN;
                        end
                    end
                end
            end
            default: begin
                n_state = stk_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stk_pkg::ST_RUN;
            r_held      <= '0;
            r_keep      <= stk_pkg::KEEP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            if (i_cfg_we) begin
                r_keep <= i_cfg_data;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word register, payload only
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_key   <= n_out_key;
            r_out_count <= n_out_count;
            r_out_last  <= n_out_last;
            r_out_empty <= n_out_empty;
        end
    end

    assign o_out.valid     = r_out_valid && i_rst_n;
    assign o_out.out_key   = r_out_key;
    assign o_out.out_count = r_out_count;
    assign o_out.last      = r_out_last;
    assign o_out.empty_res = r_out_empty;

endmodule
